// File: hw/rtl/pwfq_pkg.sv
// Shared types and constants for the port write frame queue.
// No dependencies; every file of the block but pwfq_ram imports this package.
package pwfq_pkg;

	// Queue geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int NUM_PORTS   = 4;
	localparam int DEPTH_OUT_W = 5;

	// Port byte 0xff marks a port as unset
	localparam logic [7:0] PORT_UNSET = 8'hff;

	// Chase counter reset values
	localparam logic [7:0] CHASE_THRESHOLD_RST = 8'd32;
	localparam logic [7:0] CHASE_BACKOFF_RST   = 8'd4;

	// One frame: byte i is mailbox port i
	typedef logic [NUM_PORTS-1:0][7:0] frame_t;

	localparam frame_t FRAME_EMPTY = {NUM_PORTS{PORT_UNSET}};

	// Operation codes
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_PUSH  = 2'd1,
		OP_POP   = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	// Configuration register indexes
	localparam int REG_IDX_W = 2;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_UPLOADING       = 2'd0,
		REG_CHASE_THRESHOLD = 2'd1,
		REG_CHASE_BACKOFF   = 2'd2
	} reg_idx_t;

	// Register file contents handed to the control logic
	typedef struct packed {
		logic       uploading;
		logic [7:0] chase_threshold;
		logic [7:0] chase_backoff;
	} cfg_regs_t;

	// Control sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_MERGE
	} state_t;

endpackage

// File: hw/rtl/pwfq_if.sv
// Channel interfaces of the port write frame queue: items, results, config writes.
// Depends on pwfq_pkg.
interface pwfq_item_if import pwfq_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [1:0] port;
	logic [7:0] value;

	modport source (output valid, output op, output port, output value, input ready);
	modport sink   (input valid, input op, input port, input value, output ready);
endinterface

interface pwfq_result_if import pwfq_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [7:0]             out_port0;
	logic [7:0]             out_port1;
	logic [7:0]             out_port2;
	logic [7:0]             out_port3;
	logic [NUM_PORTS-1:0]   out_mask;
	logic [DEPTH_OUT_W-1:0] queue_depth;

	modport source (output valid, output out_port0, output out_port1, output out_port2,
		output out_port3, output out_mask, output queue_depth, input ready);
	modport sink   (input valid, input out_port0, input out_port1, input out_port2,
		input out_port3, input out_mask, input queue_depth, output ready);
endinterface

interface pwfq_cfg_if import pwfq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [7:0]           data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/pwfq_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies. A read of the address written in the same cycle returns old data.
module pwfq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read ports, data held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// File: hw/rtl/pwfq_cfg.sv
// Configuration register file of the port write frame queue.
// Depends on pwfq_pkg and pwfq_cfg_if.
module pwfq_cfg import pwfq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pwfq_cfg_if.sink   cfg,
	output cfg_regs_t  regs
);

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.uploading       <= 1'b0;
			regs_q.chase_threshold <= CHASE_THRESHOLD_RST;
			regs_q.chase_backoff   <= CHASE_BACKOFF_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_UPLOADING:       regs_q.uploading       <= cfg.data[0];
				REG_CHASE_THRESHOLD: regs_q.chase_threshold <= cfg.data;
				REG_CHASE_BACKOFF:   regs_q.chase_backoff   <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

// File: hw/rtl/port_write_frame_queue_core.sv
// Top level of the port write frame queue: control sequencer around the frame store.
// Depends on pwfq_pkg, the channel interfaces, pwfq_ram and pwfq_cfg.

// Port writes, clears, empty pushes and pushes into a non-full queue need no further state.
// A pop reads the frame store, then loads the result in ST_POP, which also waits for
// the previous result to be taken. A push into a full queue writes the new frame and
// reads the two oldest frames when it is accepted; the merged frame goes back through
// the single write port in ST_MERGE. A port write while uploading is accepted only
// when the result register is free or being emptied; other operations are accepted
// while a result waits.
// The frame store needs no clearing after reset, so items are taken at once.
module port_write_frame_queue_core import pwfq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	pwfq_cfg_if.sink    cfg,
	pwfq_item_if.sink   items,
	pwfq_result_if.source results
);

	cfg_regs_t regs;

	state_t                 state_q, state_d;
	frame_t                 staging_q, staging_d;
	logic [IDX_W-1:0]       wi_q, wi_d;
	logic [CNT_W-1:0]       count_q, count_d;
	logic [7:0]             chase_q, chase_d;
	logic                   out_valid_q, out_valid_d;
	frame_t                 res_port_q, res_port_d;
	logic [NUM_PORTS-1:0]   res_mask_q, res_mask_d;
	logic [DEPTH_OUT_W-1:0] res_depth_q, res_depth_d;

	logic                   accept;
	logic                   out_free;
	logic                   do_store;
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	frame_t                 ram_wdata;
	logic                   ram_re;
	logic [IDX_W-1:0]       ram_raddr_a;
	frame_t                 rdata_a, rdata_b;
	logic [IDX_W-1:0]       wi_next;
	logic [IDX_W-1:0]       head;
	logic [CNT_W:0]         head_full;
	logic [CNT_W:0]         wi_ext, cnt_ext;
	logic [CNT_W+DEPTH_OUT_W-1:0] count_wide;
	logic                   queue_full;
	frame_t                 merged;

	pwfq_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	pwfq_ram #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH ($bits(frame_t))
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (ram_re),
		.raddr_a (ram_raddr_a),
		.raddr_b (wi_q),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// Handshake
	assign out_free    = !out_valid_q || results.ready;
	assign items.ready = (state_q == ST_IDLE)
		&& (out_free || !(items.op == OP_WRITE && regs.uploading));
	assign accept      = items.valid && items.ready;

	// Index arithmetic: next slot and oldest slot
	assign wi_next    = (wi_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wi_q + 1'b1;
	assign wi_ext     = (CNT_W + 1)'(wi_q);
	assign cnt_ext    = (CNT_W + 1)'(count_q);
	assign head_full  = (wi_ext >= cnt_ext) ? wi_ext - cnt_ext
		: wi_ext + (CNT_W + 1)'(QUEUE_DEPTH) - cnt_ext;
	assign head       = head_full[IDX_W-1:0];
	assign queue_full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign count_wide = {{DEPTH_OUT_W{1'b0}}, count_q};

	// Merge: unset ports of the second oldest frame take the oldest frame's byte
	always_comb begin
		for (int i = 0; i < NUM_PORTS; i++) begin
			merged[i] = (rdata_a[i] == PORT_UNSET) ? rdata_b[i] : rdata_a[i];
		end
	end

	// Sequencer: next state, store accesses and result load
	always_comb begin
		state_d     = state_q;
		staging_d   = staging_q;
		wi_d        = wi_q;
		count_d     = count_q;
		chase_d     = chase_q;
		out_valid_d = out_valid_q && !results.ready;
		res_port_d  = res_port_q;
		res_mask_d  = res_mask_q;
		res_depth_d = res_depth_q;
		do_store    = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = wi_q;
		ram_wdata   = staging_q;
		ram_re      = 1'b0;
		ram_raddr_a = wi_next;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (op_t'(items.op))
						OP_WRITE: begin
							if (regs.uploading) begin
								out_valid_d             = 1'b1;
								res_port_d              = '0;
								res_port_d[items.port]  = items.value;
								res_mask_d              = NUM_PORTS'(1) << items.port;
								res_depth_d             = count_wide[DEPTH_OUT_W-1:0];
							end else begin
								staging_d[items.port] = items.value;
							end
						end
						OP_PUSH: begin
							if (regs.uploading) begin
								count_d = '0;
							end else if (count_q == '0) begin
								chase_d  = '0;
								do_store = 1'b1;
							end else if (chase_q >= regs.chase_threshold
									&& staging_q == FRAME_EMPTY) begin
								chase_d = chase_q - regs.chase_backoff;
							end else begin
								chase_d  = chase_q + 8'd1;
								do_store = 1'b1;
							end
						end
						OP_POP: begin
							if (!regs.uploading && count_q != '0) begin
								count_d     = count_q - 1'b1;
								ram_re      = 1'b1;
								ram_raddr_a = head;
								state_d     = ST_POP;
							end
						end
						OP_CLEAR: begin
							wi_d      = '0;
							count_d   = '0;
							chase_d   = '0;
							staging_d = FRAME_EMPTY;
						end
					endcase
				end
			end
			ST_POP: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					for (int i = 0; i < NUM_PORTS; i++) begin
						res_mask_d[i] = (rdata_a[i] != PORT_UNSET);
						res_port_d[i] = res_mask_d[i] ? rdata_a[i] : 8'd0;
					end
					res_depth_d = count_wide[DEPTH_OUT_W-1:0];
					state_d     = ST_IDLE;
				end
			end
			ST_MERGE: begin
				// wi_q already points at the second oldest slot
				ram_we    = 1'b1;
				ram_waddr = wi_q;
				ram_wdata = merged;
				state_d   = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase

		// Store the staging frame; a full queue also reads both oldest frames
		if (do_store) begin
			ram_we    = 1'b1;
			ram_waddr = wi_q;
			ram_wdata = staging_q;
			wi_d      = wi_next;
			staging_d = FRAME_EMPTY;
			if (queue_full) begin
				ram_re      = 1'b1;
				ram_raddr_a = wi_next;
				state_d     = ST_MERGE;
			end else begin
				count_d = count_q + 1'b1;
			end
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			staging_q   <= FRAME_EMPTY;
			wi_q        <= '0;
			count_q     <= '0;
			chase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			staging_q   <= staging_d;
			wi_q        <= wi_d;
			count_q     <= count_d;
			chase_q     <= chase_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		res_port_q  <= res_port_d;
		res_mask_q  <= res_mask_d;
		res_depth_q <= res_depth_d;
	end

	assign results.valid       = out_valid_q;
	assign results.out_port0   = res_port_q[0];
	assign results.out_port1   = res_port_q[1];
	assign results.out_port2   = res_port_q[2];
	assign results.out_port3   = res_port_q[3];
	assign results.out_mask    = res_mask_q;
	assign results.queue_depth = res_depth_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("frame count above queue depth");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wi_q <= IDX_W'(QUEUE_DEPTH - 1))
		else $error("write index out of range");

	a_merge_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MERGE |=> state_q == ST_IDLE)
		else $error("merge write-back did not finish in one cycle");

	a_merge_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MERGE |-> queue_full)
		else $error("merge entered without a full queue");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !items.ready)
		else $error("item taken while a pop or merge is in progress");

endmodule
